// ===== hdl/rm5_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the two-channel recursive median filter.
package rm5_pkg;

	localparam int STAMP_BITS  = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int ITEM_BITS   = STAMP_BITS + 2 * SAMPLE_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [STAMP_BITS-1:0]         stamp_t;

	// Packed with stamp in the low bits, then channel a, then channel b.
	typedef struct packed {
		sample_t b;
		sample_t a;
		stamp_t  stamp;
	} item_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic adv;    // register updates this cycle
		logic load;   // cell takes the incoming sample
		logic shift;  // cell takes its right neighbor's value
	} cell_ctl_t;

endpackage

// ===== hdl/rm5_cell.sv =====
`timescale 1ns / 1ps
// One window slot: holds a pending sample pair and its stamp, shifts toward the head.
module rm5_cell (
	input  logic              clk,
	input  rm5_pkg::cell_ctl_t ctl,
	input  rm5_pkg::item_t    din,
	input  rm5_pkg::item_t    right,
	output rm5_pkg::item_t    eff
);
	import rm5_pkg::*;

	item_t slot_q;

	// Value seen by the window this cycle; padding slots pick up the new sample.
	assign eff = ctl.load ? din : slot_q;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			slot_q <= ctl.shift ? right : eff;
		end
	end

endmodule

// ===== hdl/rm5_median.sv =====
`timescale 1ns / 1ps
// Median selector over an odd-sized window by rank counting.
module rm5_median #(
	parameter int SPAN = 5
) (
	input  rm5_pkg::sample_t win [SPAN],
	output rm5_pkg::sample_t med
);
	import rm5_pkg::*;

	localparam int RANK_W = $clog2(SPAN);
	localparam int MID    = SPAN / 2;

	logic [RANK_W-1:0] rank [SPAN];

	// Ties break on position, so the ranks form a permutation.
	always_comb begin
		for (int i = 0; i < SPAN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < SPAN; j++) begin
				if (j != i && (win[j] < win[i] || (win[j] == win[i] && j < i))) begin
					rank[i] = rank[i] + RANK_W'(1);
				end
			end
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < SPAN; i++) begin
			if (rank[i] == RANK_W'(MID)) begin
				med = med | win[i];
			end
		end
	end

endmodule

// ===== hdl/recursive_median5_two_channel_top.sv =====
`timescale 1ns / 1ps
// Two-channel recursive median filter, top level.
//
// s_axis carries one timestamped sample pair per transaction; tlast marks the
// final sample of a run. m_axis returns one filtered pair per transaction with
// the stamp of its own sample; tlast marks the last result of the run.
// Each channel gives y[m] = median(y[m-2], y[m-1], x[m], x[m+1], x[m+2]).
// Results run WINDOW/2 samples behind the input and leave in the cycle after the
// transaction that completes their window (registered output).
// Throughput is one sample per cycle while no flush runs and the receiver keeps
// up; the median network and the feedback of past outputs close combinationally
// through a row of window slot cells. A tlast sample with f samples pending
// stalls the input while the f results flush, one per cycle unless m_axis stalls.
// When the receiver stalls, the output register holds and s_axis_tready drops
// until the pending result is taken.
// After reset no samples are pending; the first sample of a run also seeds the
// past outputs.
module recursive_median5_two_channel_top #(
	parameter int WINDOW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rm5_pkg::ITEM_BITS-1:0] s_axis_tdata,  // stamp, sample_a, sample_b
	input  logic                          s_axis_tlast,  // end_of_run
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rm5_pkg::ITEM_BITS-1:0] m_axis_tdata,  // out_stamp, filtered_a, filtered_b
	output logic                          m_axis_tlast   // final_output
);
	import rm5_pkg::*;

	localparam int HALF  = WINDOW / 2;
	localparam int SPAN  = 2 * HALF + 1;
	localparam int NCELL = HALF + 1;
	localparam int CNT_W = $clog2(HALF + 1);

	item_t            in_item;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] flush_cnt_q;
	logic             busy;
	logic             out_free;
	logic             acc;
	logic             flush_step;
	logic             full;
	logic             emit;
	logic             last_res;
	logic             adv;
	logic             seed;

	item_t            eff  [NCELL];
	sample_t          past_a_q [HALF];
	sample_t          past_b_q [HALF];
	sample_t          eff_past_a [HALF];
	sample_t          eff_past_b [HALF];
	sample_t          win_a [SPAN];
	sample_t          win_b [SPAN];
	sample_t          y_a;
	sample_t          y_b;

	logic             m_valid_q;
	item_t            m_data_q;
	logic             m_last_q;

	assign in_item = item_t'(s_axis_tdata);

	assign busy          = flush_cnt_q != '0;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !busy && out_free;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign flush_step    = busy && out_free;
	assign full          = fill_q == CNT_W'(HALF);
	assign emit          = (acc && (full || s_axis_tlast)) || flush_step;
	assign last_res      = (acc && s_axis_tlast && fill_q == '0)
		|| (flush_step && flush_cnt_q == CNT_W'(1));
	assign adv           = acc || flush_step;
	assign seed          = acc && fill_q == '0;

	// Raw window slots
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.adv   = adv;
		assign ctl.load  = acc && (CNT_W'(i) >= fill_q);
		assign ctl.shift = emit;

		rm5_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.din   (in_item),
			.right ((i == NCELL - 1) ? eff[i] : eff[(i + 1) % NCELL]),
			.eff   (eff[i])
		);

		assign win_a[HALF + i] = eff[i].a;
		assign win_b[HALF + i] = eff[i].b;
	end

	// Past outputs, oldest first
	for (genvar k = 0; k < HALF; k++) begin : g_past
		assign eff_past_a[k] = seed ? in_item.a : past_a_q[k];
		assign eff_past_b[k] = seed ? in_item.b : past_b_q[k];
		assign win_a[k]      = eff_past_a[k];
		assign win_b[k]      = eff_past_b[k];

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!emit) begin
					past_a_q[k] <= eff_past_a[k];
					past_b_q[k] <= eff_past_b[k];
				end else if (k == HALF - 1) begin
					past_a_q[k] <= y_a;
					past_b_q[k] <= y_b;
				end else begin
					past_a_q[k] <= eff_past_a[(k + 1) % HALF];
					past_b_q[k] <= eff_past_b[(k + 1) % HALF];
				end
			end
		end
	end

	rm5_median #(.SPAN(SPAN)) u_med_a (
		.win (win_a),
		.med (y_a)
	);

	rm5_median #(.SPAN(SPAN)) u_med_b (
		.win (win_b),
		.med (y_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			flush_cnt_q <= '0;
		end else begin
			if (acc) begin
				if (s_axis_tlast) begin
					fill_q      <= '0;
					flush_cnt_q <= fill_q;
				end else if (!full) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end else if (flush_step) begin
				flush_cnt_q <= flush_cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q.stamp <= eff[0].stamp;
			m_data_q.a     <= y_a;
			m_data_q.b     <= y_b;
			m_last_q       <= last_res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule
